// File: rtl/iate_pkg.sv
package iate_pkg;

  // Fixed field widths of the request and result words.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned FUNC_W = 3;

  // Default table depth and the capacity register's reset value.
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd10;

  // Request codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_SEARCH = 3'd2,
    FUNC_GET    = 3'd3,
    FUNC_SET    = 3'd4,
    FUNC_SUM    = 3'd5
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Access to the entry memory: one write and one read address per cycle.
  typedef struct packed {
    logic               we;
    logic [COUNT_W-1:0] waddr;
    logic [DATA_W-1:0]  wdata;
    logic [COUNT_W-1:0] raddr;
  } mem_req_t;

  // One finished result word.
  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   found;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// File: rtl/iate_store.sv
module iate_store #(
  parameter int unsigned MAX_ENTRIES = iate_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  iate_pkg::mem_req_t        req_i,
  output logic [iate_pkg::DATA_W-1:0] rdata_o
);
  import iate_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [DATA_W-1:0] mem [MAX_ENTRIES];
  logic [DATA_W-1:0] rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[AW'(req_i.waddr)] <= req_i.wdata;
    end
    rdata_q <= mem[AW'(req_i.raddr)];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/iate_seq.sv
module iate_seq #(
  parameter int unsigned MAX_ENTRIES = iate_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  iate_pkg::func_e              func_i,
  input  logic [iate_pkg::POS_W-1:0]   pos_i,
  input  logic [iate_pkg::DATA_W-1:0]  val_i,
  input  logic [iate_pkg::COUNT_W-1:0] cap_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output iate_pkg::result_t            res_o,
  output iate_pkg::mem_req_t           mem_o,
  input  logic [iate_pkg::DATA_W-1:0]  rdata_i
);
  import iate_pkg::*;

  // The count register can never exceed the table depth or its own range.
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned CAP_LIMIT = (MAX_ENTRIES > COUNT_MAX) ? COUNT_MAX : MAX_ENTRIES;
  localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(CAP_LIMIT);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_WALK_UP   = 11'b000_0000_0010,
    S_WALK_DOWN = 11'b000_0000_0100,
    S_DRAIN     = 11'b000_0000_1000,
    S_PUT       = 11'b000_0001_0000,
    S_SWAP_A    = 11'b000_0010_0000,
    S_SWAP_B    = 11'b000_0100_0000,
    S_WRITE     = 11'b000_1000_0000,
    S_READ      = 11'b001_0000_0000,
    S_READ_WAIT = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_e;

  state_e             state_q, state_d;
  func_e              op_q, op_d;
  logic [COUNT_W-1:0] pos_q, pos_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [COUNT_W-1:0] ptr_q, ptr_d;
  logic [COUNT_W-1:0] prev_q, prev_d;
  logic               pend_q, pend_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]   found_q, found_d;
  status_e            status_q, status_d;

  logic [COUNT_W-1:0] pos_ext;
  logic [COUNT_W-1:0] cnt_last;
  logic               full;
  logic [DATA_W-1:0]  alu_sum;
  logic               alu_eq;
  logic               hit;

  assign pos_ext  = COUNT_W'(pos_i);
  assign cnt_last = cnt_q - 1'b1;
  assign full     = (cnt_q >= cap_i) || (cnt_q >= CAP_MAX);

  // Shared arithmetic unit: one adder for the running sum, one comparator for search.
  assign alu_sum = acc_q + rdata_i;
  assign alu_eq  = (rdata_i == val_q);
  assign hit     = pend_q && (op_q == FUNC_SEARCH) && alu_eq;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    prev_d    = ptr_q;
    pend_d    = 1'b0;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    found_d   = found_q;
    status_d  = status_q;
    mem_o     = '0;
    mem_o.raddr = ptr_q;

    // Handle the word that the read issued last cycle brought back.
    if (pend_q) begin
      case (op_q)
        FUNC_INSERT: begin
          mem_o.we    = 1'b1;
          mem_o.waddr = prev_q + 1'b1;
          mem_o.wdata = rdata_i;
        end
        FUNC_DELETE: begin
          if (prev_q == pos_q) begin
            acc_d = rdata_i;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = prev_q - 1'b1;
            mem_o.wdata = rdata_i;
          end
        end
        FUNC_SEARCH: begin
          if (prev_q == '0) begin
            acc_d = rdata_i;
          end
        end
        FUNC_SUM: begin
          acc_d = alu_sum;
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = func_i;
          pos_d    = pos_ext;
          val_d    = val_i;
          acc_d    = '0;
          found_d  = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (func_i)
            FUNC_INSERT: begin
              if (pos_ext > cnt_q) begin
                status_d = ST_BAD_INDEX;
              end else if (full) begin
                status_d = ST_FULL;
              end else if (pos_ext == cnt_q) begin
                state_d = S_PUT;
              end else begin
                ptr_d   = cnt_last;
                state_d = S_WALK_DOWN;
              end
            end
            FUNC_DELETE: begin
              if (pos_ext >= cnt_q) begin
                status_d = ST_BAD_INDEX;
              end else begin
                ptr_d   = pos_ext;
                state_d = S_WALK_UP;
              end
            end
            FUNC_SEARCH: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ptr_d   = '0;
                state_d = S_WALK_UP;
              end
            end
            FUNC_GET: begin
              if (pos_ext >= cnt_q) begin
                status_d = ST_BAD_INDEX;
              end else begin
                state_d = S_READ;
              end
            end
            FUNC_SET: begin
              if (pos_ext >= cnt_q) begin
                status_d = ST_BAD_INDEX;
              end else begin
                state_d = S_WRITE;
              end
            end
            FUNC_SUM: begin
              if (cnt_q != '0) begin
                ptr_d   = '0;
                state_d = S_WALK_UP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Forward walk for delete, search and sum: one read per cycle.
      S_WALK_UP: begin
        pend_d = 1'b1;
        if (hit) begin
          pend_d  = 1'b0;
          found_d = POS_W'(prev_q);
          state_d = S_SWAP_A;
        end else if (ptr_q == cnt_last) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Backward walk for insert: each entry moves up by one.
      S_WALK_DOWN: begin
        pend_d = 1'b1;
        if (ptr_q == pos_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end

      // The last read word is handled here; then finish per operation.
      S_DRAIN: begin
        state_d = S_DONE;
        case (op_q)
          FUNC_INSERT: state_d = S_PUT;
          FUNC_DELETE: cnt_d = cnt_q - 1'b1;
          FUNC_SEARCH: begin
            if (hit) begin
              found_d = POS_W'(prev_q);
              state_d = S_SWAP_A;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end

      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = val_q;
        cnt_d       = cnt_q + 1'b1;
        state_d     = S_DONE;
      end

      // Old entry 0 moves to the hit's place, then the key goes to entry 0.
      S_SWAP_A: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = COUNT_W'(found_q);
        mem_o.wdata = acc_q;
        state_d     = S_SWAP_B;
      end

      S_SWAP_B: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = '0;
        mem_o.wdata = val_q;
        state_d     = S_DONE;
      end

      S_WRITE: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = val_q;
        state_d     = S_DONE;
      end

      S_READ: begin
        mem_o.raddr = pos_q;
        state_d     = S_READ_WAIT;
      end

      S_READ_WAIT: begin
        acc_d   = rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    prev_q   <= prev_d;
    acc_q    <= acc_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.value  = (op_q == FUNC_SEARCH) ? '0 : acc_q;
  assign res_o.found  = found_q;
  assign res_o.count  = cnt_q;

endmodule

// File: rtl/indexed_array_table_engine.sv
// Dense table of signed 32-bit entries with a running entry count.
// Request channel: in_valid_i / in_stall_o carry one word of func_i, position_i and
// operand_value_i (insert, delete, search, get, set, sum). Result channel:
// out_valid_o / out_stall_i carry status_o, result_value_o, found_position_o and
// entry_count_o, exactly one result word per request word.
// The block handles one request at a time and holds in_stall_o high until its
// result has moved into the output register. Insert walks down from the last entry
// to the position (no walk when appending at the end), delete walks up from the
// position, search walks up from entry 0 until a hit and then swaps it to entry 0,
// sum walks the whole table (no walk when empty); get, set and rejected requests
// need no walk. The walks are set by the entry memory's single registered read
// port, one entry per cycle, and by the shared add/compare unit. A full output
// register does not block acceptance of the next request; only the hand-over of a
// finished result waits while that register is full and out_stall_i is high. The
// capacity register sits at byte address 0 of the APB port; the user must write
// it only while the block is idle, which the block does not enforce. Reset empties
// the table (count zero) and sets capacity to 10; memory needs no clear or sweep.
module indexed_array_table_engine #(
  parameter int unsigned MAX_ENTRIES = iate_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [iate_pkg::FUNC_W-1:0]         func_i,
  input  logic [iate_pkg::POS_W-1:0]          position_i,
  input  logic signed [iate_pkg::DATA_W-1:0]  operand_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [iate_pkg::DATA_W-1:0]  result_value_o,
  output logic [iate_pkg::POS_W-1:0]          found_position_o,
  output logic [iate_pkg::COUNT_W-1:0]        entry_count_o
);
  import iate_pkg::*;

  localparam logic REG_CAPACITY = 1'b0;

  logic [COUNT_W-1:0] cap_q, cap_d;
  logic               cfg_write;
  logic               busy;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  mem_req_t           mem_req;
  logic [DATA_W-1:0]  rdata;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  // Configuration port: capacity register only.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign cap_d     = cfg_write ? pwdata[COUNT_W-1:0] : cap_q;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(32 - COUNT_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Sequencer and entry memory.
  iate_seq #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .func_i     (func_e'(func_i)),
    .pos_i      (position_i),
    .val_i      ($unsigned(operand_value_i)),
    .cap_i      (cap_q),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_o      (mem_req),
    .rdata_i    (rdata)
  );

  iate_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  assign in_stall_o = busy;

  // Output register: takes a result when empty or when its word leaves this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign result_value_o   = $signed(out_q.value);
  assign found_position_o = out_q.found;
  assign entry_count_o    = out_q.count;

endmodule

// File: tb/indexed_array_table_engine_tb.sv
module indexed_array_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iate_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DEPTH = MAX_ENTRIES_DEF;
  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  // Predicts the table contents and count, and holds the result words still owed.
  class array_table_scoreboard;
    logic [DATA_W-1:0] entries[DEPTH];
    int unsigned used;
    int unsigned capacity_reg;
    result_t expected_results[$];
    int unsigned errors;

    function new();
      used = 0;
      capacity_reg = 32'(CAPACITY_RESET);
      errors = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void write_capacity(logic [31:0] value);
      capacity_reg = {25'd0, value[6:0]};
    endfunction

    // Applies one accepted request word and queues the result word it must produce.
    function void apply_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                logic [DATA_W-1:0] v);
      result_t r;
      int unsigned cap;
      int i;
      logic [DATA_W-1:0] acc;
      r = '0;
      cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      case (f)
        FUNC_INSERT: begin
          if (p > used) begin
            r.status = ST_BAD_INDEX;
          end else if (used >= cap) begin
            r.status = ST_FULL;
          end else begin
            for (i = int'(used); i > int'(p); i--) entries[i] = entries[i-1];
            entries[p] = v;
            used++;
          end
        end
        FUNC_DELETE: begin
          if (p >= used) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.value = entries[p];
            for (i = int'(p); i + 1 < int'(used); i++) entries[i] = entries[i+1];
            used--;
          end
        end
        FUNC_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < int'(used); i++) begin
            if (entries[i] == v) begin
              entries[i] = entries[0];
              entries[0] = v;
              r.found = i[POS_W-1:0];
              r.status = ST_OK;
              break;
            end
          end
        end
        FUNC_GET: begin
          if (p >= used) r.status = ST_BAD_INDEX;
          else r.value = entries[p];
        end
        FUNC_SET: begin
          if (p >= used) r.status = ST_BAD_INDEX;
          else entries[p] = v;
        end
        FUNC_SUM: begin
          acc = '0;
          for (i = 0; i < int'(used); i++) acc = acc + entries[i];
          r.value = acc;
        end
        default: begin
        end
      endcase
      r.count = used[COUNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_result(logic [1:0] st, logic [DATA_W-1:0] value,
                               logic [POS_W-1:0] found, logic [COUNT_W-1:0] count);
      result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d value %0h",
                 $time, st, value);
        errors++;
      end else begin
        r = expected_results.pop_front();
        compare_field("status", 32'(r.status), 32'(st));
        compare_field("result_value", r.value, value);
        compare_field("found_position", 32'(r.found), 32'(found));
        compare_field("entry_count", 32'(r.count), 32'(count));
      end
    endfunction

    function void flag_leftovers();
      if (expected_results.size() != 0) begin
        $display("%0t: results missing, expected %0d more, actual 0", $time,
                 expected_results.size());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_stall_o;
  logic [FUNC_W-1:0] func_i;
  logic [POS_W-1:0] position_i;
  logic signed [DATA_W-1:0] operand_value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] status_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic [POS_W-1:0] found_position_o;
  logic [COUNT_W-1:0] entry_count_o;

  bit calm;
  int unsigned cycle_count;
  array_table_scoreboard sb;

  indexed_array_table_engine uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .position_i       (position_i),
    .operand_value_i  (operand_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_value_o   (result_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_array_table_engine_tb NOT OK");
      $finish;
    end
  end

  // Result side: random stall at the falling edge, check at the rising edge.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(status_o, result_value_o, found_position_o, entry_count_o);
    end
  end

  // Presents one request word, with random idle cycles ahead of it, until accepted.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    position_i <= p;
    operand_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.apply_request(f, p, v);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every owed result word has arrived and the block is idle.
  task automatic drain();
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes it at that edge.
  task automatic write_capacity(input logic [6:0] cap);
    logic [31:0] word;
    word = $urandom;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {word[31:7], cap};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_capacity({word[31:7], cap});
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2: v = $urandom_range(7);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // One random request word, mostly well-formed for the current table.
  task automatic send_random(input int unsigned insert_pct);
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0] p;
    logic [DATA_W-1:0] v;
    int unsigned n;
    int unsigned roll;
    n = sb.used;
    if ($urandom_range(99) < insert_pct) begin
      f = FUNC_INSERT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30) f = FUNC_DELETE;
      else if (roll < 55) f = FUNC_SEARCH;
      else if (roll < 70) f = FUNC_GET;
      else if (roll < 85) f = FUNC_SET;
      else if (roll < 97) f = FUNC_SUM;
      else f = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    end
    if ($urandom_range(99) < 12) p = POS_W'($urandom);
    else if (f == FUNC_INSERT) p = POS_W'($urandom_range((n > 63) ? 63 : n));
    else if (n > 0) p = POS_W'($urandom_range(n - 1));
    else p = POS_W'($urandom);
    v = pick_value();
    if (f == FUNC_SEARCH && n > 0 && $urandom_range(99) < 70) begin
      v = sb.entries[$urandom_range(n - 1)];
    end
    send_word(f, p, v);
  endtask

  // One setting of the capacity register and a run of random words under it.
  task automatic run_phase(input logic [6:0] cap, input int unsigned items,
                           input int unsigned insert_pct, input bit quiet);
    drain();
    write_capacity(cap);
    calm = quiet;
    for (int k = 0; k < items; k++) begin
      send_random(insert_pct);
      if (k % 150 == 149) begin
        release_input();
        drain();
      end
    end
    release_input();
    calm = 1'b0;
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    func_i = '0;
    position_i = '0;
    operand_value_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Empty table: sum of nothing, out-of-range indexes, a miss, insert past the count.
    send_word(FUNC_SUM, 6'd0, 32'd0);
    send_word(FUNC_DELETE, 6'd0, 32'd0);
    send_word(FUNC_GET, 6'd0, 32'd0);
    send_word(FUNC_SET, 6'd0, 32'h1234_5678);
    send_word(FUNC_SEARCH, 6'd0, 32'd0);
    send_word(FUNC_INSERT, 6'd1, 32'd5);

    // Fill with extreme values, wrap the sum, hit a search away from entry zero.
    send_word(FUNC_INSERT, 6'd0, 32'h7FFF_FFFF);
    send_word(FUNC_INSERT, 6'd1, 32'h8000_0000);
    send_word(FUNC_INSERT, 6'd0, 32'h0000_0000);
    send_word(FUNC_INSERT, 6'd3, 32'hFFFF_FFFF);
    send_word(FUNC_SUM, 6'd0, 32'd0);
    send_word(FUNC_SEARCH, 6'd0, 32'h8000_0000);
    send_word(FUNC_GET, 6'd0, 32'd0);
    send_word(FUNC_SET, 6'd3, 32'h5555_5555);
    send_word(FUNC_GET, 6'd63, 32'd0);
    send_word(FUNC_SPARE_6, 6'd63, 32'hFFFF_FFFF);
    send_word(FUNC_SPARE_7, 6'd0, 32'd0);
    send_word(FUNC_DELETE, 6'd3, 32'd0);
    send_word(FUNC_DELETE, 6'd0, 32'd0);
    send_word(FUNC_SEARCH, 6'd0, 32'h0BAD_F00D);
    release_input();

    // Full table; a bad index wins over full.
    drain();
    write_capacity(7'd2);
    send_word(FUNC_INSERT, 6'd0, 32'd1);
    send_word(FUNC_INSERT, 6'd63, 32'd1);
    release_input();

    // Zero capacity, and a capacity below the count.
    drain();
    write_capacity(7'd0);
    send_word(FUNC_INSERT, 6'd0, 32'd2);
    send_word(FUNC_SUM, 6'd0, 32'd0);
    send_word(FUNC_DELETE, 6'd1, 32'd0);
    release_input();

    // Random part over several capacity settings.
    run_phase(7'd64, 450, 55, 1'b0);
    run_phase(7'd127, 300, 35, 1'b1);
    run_phase(7'd1, 200, 40, 1'b0);
    run_phase(7'd10, 250, 45, 1'b0);
    run_phase(7'd0, 100, 20, 1'b0);
    run_phase(7'($urandom_range(1, 64)), 200, 50, 1'b0);
    run_phase(7'd64, 250, 30, 1'b0);
    run_phase(7'($urandom_range(2, 63)), 200, 45, 1'b0);

    drain();
    repeat (70) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("indexed_array_table_engine_tb OK");
    end else begin
      $display("indexed_array_table_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
